@@ hdl/rhsv_pkg.sv @@
`timescale 1ns / 1ps

package rhsv_pkg;

  localparam int CHAN_W = 8;
  localparam int QUO_W  = 16;
  localparam int SPAN_W = 11;
  localparam int STEPS  = QUO_W;

  typedef struct packed {
    logic [CHAN_W-1:0] sat_rem;
    logic [CHAN_W-1:0] sat_div;
    logic [QUO_W-1:0]  sat_low;
    logic [QUO_W-1:0]  sat_quo;
    logic [SPAN_W-1:0] hue_rem;
    logic [SPAN_W-1:0] hue_div;
    logic [QUO_W-1:0]  hue_quo;
    logic [CHAN_W-1:0] bright;
    logic              grey;
  } rhsv_data_t;

endpackage

@@ hdl/rhsv_in_if.sv @@
`timescale 1ns / 1ps

interface rhsv_in_if;
  import rhsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

@@ hdl/rhsv_out_if.sv @@
`timescale 1ns / 1ps

interface rhsv_out_if;
  import rhsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [QUO_W-1:0]  hue;
  logic [QUO_W-1:0]  saturation;
  logic [CHAN_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

@@ hdl/rhsv_front.sv @@
`timescale 1ns / 1ps

module rhsv_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   red,
  input  logic [7:0]                   green,
  input  logic [7:0]                   blue,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rhsv_pkg::rhsv_data_t         out_data
);
  import rhsv_pkg::*;

  logic              valid_r, valid_nxt;
  rhsv_data_t        data_r, data_nxt;
  logic              r_max, g_max;
  logic [CHAN_W-1:0] hi, lo, delta;
  logic [SPAN_W-1:0] span;
  logic [11:0]       base, diff, n_raw, n_fix;
  logic [23:0]       sat_x;

  always_comb begin
    r_max = (red >= green) && (red >= blue);
    g_max = !r_max && (green >= blue);
    hi = r_max ? red : (g_max ? green : blue);
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    delta = hi - lo;
    span = ({3'b000, delta} << 2) + ({3'b000, delta} << 1);
    if (r_max) begin
      base = 12'd0;
      diff = {4'b0000, green} - {4'b0000, blue};
    end else if (g_max) begin
      base = {3'b000, delta, 1'b0};
      diff = {4'b0000, blue} - {4'b0000, red};
    end else begin
      base = {2'b00, delta, 2'b00};
      diff = {4'b0000, red} - {4'b0000, green};
    end
    n_raw = base + diff;
    n_fix = n_raw[11] ? (n_raw + {1'b0, span}) : n_raw;
    sat_x = {delta, 16'h0000} - {16'h0000, delta};

    data_nxt.sat_rem = sat_x[23:16];
    data_nxt.sat_div = hi;
    data_nxt.sat_low = sat_x[15:0];
    data_nxt.sat_quo = '0;
    data_nxt.hue_rem = n_fix[SPAN_W-1:0];
    data_nxt.hue_div = span;
    data_nxt.hue_quo = '0;
    data_nxt.bright  = hi;
    data_nxt.grey    = (delta == '0);
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  a_hue_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !data_r.grey |-> data_r.hue_rem < data_r.hue_div)
    else $error("hue remainder not below span");

endmodule

@@ hdl/rhsv_cell.sv @@
`timescale 1ns / 1ps

module rhsv_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rhsv_pkg::rhsv_data_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rhsv_pkg::rhsv_data_t out_data
);
  import rhsv_pkg::*;

  logic              valid_r, valid_nxt;
  rhsv_data_t        data_r, data_nxt;
  logic [CHAN_W:0]   sat_t;
  logic [SPAN_W:0]   hue_t;
  logic              sat_bit, hue_bit;

  // one restoring step for each quotient
  always_comb begin
    sat_t   = {in_data.sat_rem, in_data.sat_low[QUO_W-1]};
    hue_t   = {in_data.hue_rem, 1'b0};
    sat_bit = sat_t >= {1'b0, in_data.sat_div};
    hue_bit = hue_t >= {1'b0, in_data.hue_div};
    data_nxt = in_data;
    data_nxt.sat_rem = sat_bit ? CHAN_W'(sat_t - {1'b0, in_data.sat_div})
                               : sat_t[CHAN_W-1:0];
    data_nxt.hue_rem = hue_bit ? SPAN_W'(hue_t - {1'b0, in_data.hue_div})
                               : hue_t[SPAN_W-1:0];
    data_nxt.sat_low = {in_data.sat_low[QUO_W-2:0], 1'b0};
    data_nxt.sat_quo = {in_data.sat_quo[QUO_W-2:0], sat_bit};
    data_nxt.hue_quo = {in_data.hue_quo[QUO_W-2:0], hue_bit};
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  a_sat_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !data_r.grey |-> data_r.sat_rem < data_r.sat_div)
    else $error("saturation remainder not below divisor");

  a_hue_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !data_r.grey |-> data_r.hue_rem < data_r.hue_div)
    else $error("hue remainder not below divisor");

endmodule

@@ hdl/rgb_to_hsv_pixel.sv @@
`timescale 1ns / 1ps
// RGB to HSV converter, 8-bit channels in, 16-bit hue and saturation out.
// Input channel in_px: red, green, blue; accepted when valid and ready.
// Output channel out_px: hue (1/65536 turn), saturation (delta*65535/max,
// truncated), brightness (max channel byte).
// Structure: one front stage finds max/min and sets up two dividends, then
// a row of 16 identical cells, each producing one quotient bit of both the
// hue and the saturation division and passing its remainders on.
// Pipeline: 17 register stages, the front stage and the 16 cells; out_px.valid
// is the valid register of the last cell. Each stage holds one item.
// Throughput: one pixel per cycle while out_px.ready is high.
// Each stage has its own valid and takes a new item when empty or when
// its neighbor downstream takes its item, so bubbles close up.
// Receiver stall: the last cell holds its result; items queue up behind it
// and in_px.ready drops only once all 17 stages are full.
// Reset (rst_n low, synchronous) empties every stage; no result is lost
// or repeated across a stall.
module rgb_to_hsv_pixel (
  input logic        clk,
  input logic        rst_n,
  rhsv_in_if.sink    in_px,
  rhsv_out_if.source out_px
);
  import rhsv_pkg::*;

  logic       vld   [0:STEPS];
  logic       rdy   [0:STEPS];
  rhsv_data_t data  [0:STEPS];
  logic [STEPS:0] vld_vec;

  rhsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_px.valid),
    .in_ready  (in_px.ready),
    .red       (in_px.red),
    .green     (in_px.green),
    .blue      (in_px.blue),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_data  (data[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    rhsv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_data   (data[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_data  (data[k+1])
    );
  end

  always_comb begin
    for (int k = 0; k <= STEPS; k++) begin
      vld_vec[k] = vld[k];
    end
  end

  assign rdy[STEPS]        = out_px.ready;
  assign out_px.valid      = vld[STEPS];
  assign out_px.hue        = data[STEPS].grey ? '0 : data[STEPS].hue_quo;
  assign out_px.saturation = data[STEPS].grey ? '0 : data[STEPS].sat_quo;
  assign out_px.brightness = data[STEPS].bright;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_px.ready |-> (&vld_vec) && !out_px.ready)
    else $error("input stalled while pipeline has a free stage");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rhsv_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 2000;

  typedef struct packed {
    logic [QUO_W-1:0]  hue;
    logic [QUO_W-1:0]  saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_t;

  logic clk;
  logic rst_n;

  rhsv_in_if  in_px ();
  rhsv_out_if out_px ();

  rgb_to_hsv_pixel u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_px (out_px)
  );

  hsv_t pending_hsv[$];
  int   n_sent;
  int   n_grey;
  int   n_checked;
  int   n_errors;
  int   send_idle_pct;
  int   recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic hsv_t predict_hsv(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                       logic [CHAN_W-1:0] b);
    hsv_t   res;
    int     hi;
    int     lo;
    int     delta;
    int     n;
    longint scaled;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    res.hue = '0;
    res.saturation = '0;
    res.brightness = hi[CHAN_W-1:0];
    if (delta != 0) begin
      res.saturation = QUO_W'((delta * 65535) / hi);
      if (r == hi) begin
        n = int'(g) - int'(b);
      end else if (g == hi) begin
        n = 2 * delta + int'(b) - int'(r);
      end else begin
        n = 4 * delta + int'(r) - int'(g);
      end
      if (n < 0) n += 6 * delta;
      scaled = (longint'(n) * 65536) / longint'(6 * delta);
      res.hue = scaled[QUO_W-1:0];
    end
    return res;
  endfunction

  function automatic int pick_idle(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                            logic [CHAN_W-1:0] b);
    int gap;
    gap = pick_idle(send_idle_pct);
    repeat (gap) begin
      in_px.valid <= 1'b0;
      @(negedge clk);
    end
    in_px.valid <= 1'b1;
    in_px.red   <= r;
    in_px.green <= g;
    in_px.blue  <= b;
    do @(posedge clk); while (!in_px.ready);
    pending_hsv.insert(pending_hsv.size(), predict_hsv(r, g, b));
    n_sent++;
    if (r == g && g == b) n_grey++;
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'h00);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h01);
    send_pixel(8'hff, 8'h00, 8'hfe);
    send_pixel(8'h01, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h01, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h01);
    send_pixel(8'hff, 8'hfe, 8'hfe);
    send_pixel(8'hfe, 8'hff, 8'hfe);
    send_pixel(8'hfe, 8'hfe, 8'hff);
    send_pixel(8'haa, 8'h55, 8'haa);
    send_pixel(8'h55, 8'haa, 8'h55);
    send_pixel(8'h01, 8'h01, 8'h00);
    send_pixel(8'h00, 8'h80, 8'hff);
    send_pixel(8'h7f, 8'h80, 8'h81);
  endtask

  task automatic test_uniform_pixels(int count);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    repeat (count) begin
      send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
    end
  endtask

  // greys, ties for the maximum, tiny spreads and saturated channels
  task automatic test_edge_pixels(int count);
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] c;
    logic [CHAN_W-1:0] px[3];
    int                sel;
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    repeat (count) begin
      a = CHAN_W'($urandom);
      c = CHAN_W'($urandom_range(0, a));
      sel = $urandom_range(0, 2);
      case ($urandom_range(0, 5))
        0: begin
          px[0] = a; px[1] = a; px[2] = a;
        end
        1: begin
          px[0] = a; px[1] = a; px[2] = c;
        end
        2: begin
          px[0] = CHAN_W'($urandom_range(0, 3));
          px[1] = CHAN_W'($urandom_range(0, 3));
          px[2] = CHAN_W'($urandom_range(0, 3));
        end
        3: begin
          px[0] = 8'hff; px[1] = a; px[2] = c;
        end
        4: begin
          px[0] = 8'h00; px[1] = a; px[2] = c;
        end
        default: begin
          px[0] = a; px[1] = a - CHAN_W'($urandom_range(0, 2)); px[2] = c;
        end
      endcase
      case (sel)
        0: send_pixel(px[0], px[1], px[2]);
        1: send_pixel(px[2], px[0], px[1]);
        default: send_pixel(px[1], px[2], px[0]);
      endcase
    end
  endtask

  task automatic test_full_rate(int count);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (count) begin
      send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
    end
  endtask

  task automatic test_heavy_stall(int count);
    send_idle_pct  = 5;
    recv_stall_pct = 70;
    repeat (count) begin
      send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
    end
  endtask

  task automatic test_sparse_source(int count);
    send_idle_pct  = 70;
    recv_stall_pct = 10;
    repeat (count) begin
      send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
    end
  endtask

  // sink side
  initial begin
    int stall_left;
    out_px.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) stall_left = pick_idle(recv_stall_pct);
      if (stall_left > 0) begin
        stall_left--;
        out_px.ready <= 1'b0;
      end else begin
        out_px.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    hsv_t want;
    if (rst_n && out_px.valid && out_px.ready) begin
      if (pending_hsv.size() == 0) begin
        $error("unexpected result hue=%0d saturation=%0d brightness=%0d",
               out_px.hue, out_px.saturation, out_px.brightness);
        n_errors++;
      end else begin
        want = pending_hsv.pop_front();
        n_checked++;
        if (out_px.hue !== want.hue) begin
          $error("hue expected %0d got %0d", want.hue, out_px.hue);
          n_errors++;
        end
        if (out_px.saturation !== want.saturation) begin
          $error("saturation expected %0d got %0d", want.saturation, out_px.saturation);
          n_errors++;
        end
        if (out_px.brightness !== want.brightness) begin
          $error("brightness expected %0d got %0d", want.brightness, out_px.brightness);
          n_errors++;
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, pending_hsv.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    n_sent         = 0;
    n_grey         = 0;
    n_checked      = 0;
    n_errors       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    in_px.valid    = 1'b0;
    in_px.red      = '0;
    in_px.green    = '0;
    in_px.blue     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_uniform_pixels(450);
    test_edge_pixels(350);
    test_full_rate(150);
    test_heavy_stall(150);
    test_sparse_source(100);
    in_px.valid <= 1'b0;

    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d pixels (%0d grey), %0d results compared, %0d field errors",
             n_sent, n_grey, n_checked, n_errors);
    $display("covered greys, max-channel ties, hue wrap, full rate and long sink stalls");
    if (n_errors == 0 && pending_hsv.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
